### sv/ldsplit_pkg.sv
package ldsplit_pkg;

  // Header layout and the shortest legal document (header plus body)
  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned MIN_DOC_LEN = 9;
  localparam int unsigned MB_SHIFT = 20;

  localparam int unsigned SPLIT_MB_W = 11;
  localparam int unsigned STATUS_W = 3;

  localparam logic [SPLIT_MB_W-1:0] SPLIT_MB_RESET = 11'd1;

  // Status codes carried on the result channel
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLEAN_END = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TRUNC_HDR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LEN_SHORT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNC_DOC = 3'd4;

endpackage

### sv/length_prefixed_doc_splitter.sv
// Splits a byte stream of length-prefixed documents (4-byte little-endian
// length that counts itself) into numbered splits. Header bytes one to three
// are held back and produce no result; when the fourth arrives the length is
// checked, and a negative length or one below 9 gives a single status request
// (length too short) and halts the block. A valid header is sent as four byte
// requests, then each body byte as one request tagged with the split number.
// On the last byte of a document the split byte count is compared against
// split_size_mb * 2^20 and, when strictly greater, the split closes and the
// next bytes belong to the next split. An end_of_input request gives one status
// request (clean end, truncated header or truncated document) and halts; bytes
// of a truncated document have already gone out and must be discarded. After a
// halt every input request is taken and dropped until reset. Rate: one input
// byte per cycle while the output advances, except the fourth header byte,
// which closes the input side while the other header bytes drain, one per
// cycle as the output advances, through the single output register; results
// use it, so input is taken in the same cycle the previous result is taken.
module length_prefixed_doc_splitter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [ldsplit_pkg::SPLIT_MB_W-1:0]   cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_byte,
  input  logic                                 end_of_input,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_byte,
  output logic                                 byte_valid,
  output logic [31:0]                          split_number,
  output logic                                 doc_last,
  output logic                                 split_close,
  output logic [31:0]                          docs_in_split,
  output logic [ldsplit_pkg::STATUS_W-1:0]     status,
  output logic                                 run_last
);

  typedef enum logic [1:0] {PH_HEADER, PH_BODY, PH_HALT} phase_t;

  typedef struct packed {
    logic [7:0]                       out_byte;
    logic                             byte_valid;
    logic [31:0]                      split_number;
    logic                             doc_last;
    logic                             split_close;
    logic [31:0]                      docs_in_split;
    logic [ldsplit_pkg::STATUS_W-1:0] status;
    logic                             run_last;
  } result_t;

  logic [ldsplit_pkg::SPLIT_MB_W-1:0] split_size_mb;
  phase_t      phase, phase_next;
  logic [23:0] header_held, header_held_next;
  logic [1:0]  header_count, header_count_next;
  logic [1:0]  hdr_pend, hdr_pend_next;
  logic [30:0] body_remaining, body_remaining_next;
  logic [32:0] split_bytes, split_bytes_next;
  logic [31:0] split_index, split_index_next;
  logic [31:0] doc_count, doc_count_next;

  result_t res;
  logic    emit;
  logic    adv;
  logic    fire_in;

  logic [31:0] hdr_len;
  logic [30:0] rem_dec;
  logic [32:0] bytes_inc;
  logic [32:0] limit;
  logic        close_now;
  logic [31:0] docs_inc;

  // Output register can take a new request when empty or being drained
  assign adv      = out_ready || !out_valid;
  assign in_ready = (hdr_pend == 2'd0) && adv;
  assign fire_in  = in_valid && in_ready;

  assign hdr_len   = {in_byte, header_held};
  assign rem_dec   = body_remaining - 31'd1;
  assign bytes_inc = split_bytes + 33'd1;
  assign limit     = {2'b00, split_size_mb, 20'h00000};
  assign close_now = bytes_inc > limit;
  assign docs_inc  = doc_count + 32'd1;

  // Next state and the result request for this cycle
  always_comb begin
    phase_next          = phase;
    header_held_next    = header_held;
    header_count_next   = header_count;
    hdr_pend_next       = hdr_pend;
    body_remaining_next = body_remaining;
    split_bytes_next    = split_bytes;
    split_index_next    = split_index;
    doc_count_next      = doc_count;
    emit                = 1'b0;
    res                 = '0;
    res.split_number    = split_index;
    res.run_last        = 1'b1;
    if (hdr_pend != 2'd0) begin
      // Drain the held header bytes, one per cycle while the output advances
      if (adv) begin
        emit             = 1'b1;
        res.out_byte     = header_held[7:0];
        res.byte_valid   = 1'b1;
        res.run_last     = (hdr_pend == 2'd1);
        header_held_next = {8'h00, header_held[23:8]};
        hdr_pend_next    = hdr_pend - 2'd1;
      end
    end else if (fire_in && phase != PH_HALT) begin
      if (end_of_input) begin
        emit       = 1'b1;
        phase_next = PH_HALT;
        if (phase == PH_BODY) begin
          res.status = ldsplit_pkg::ST_TRUNC_DOC;
        end else if (header_count == 2'd0) begin
          res.status = ldsplit_pkg::ST_CLEAN_END;
        end else begin
          res.status = ldsplit_pkg::ST_TRUNC_HDR;
        end
      end else if (phase == PH_HEADER) begin
        if (header_count != 2'd3) begin
          // Hold header bytes one to three
          case (header_count)
            2'd0:    header_held_next[7:0]   = in_byte;
            2'd1:    header_held_next[15:8]  = in_byte;
            default: header_held_next[23:16] = in_byte;
          endcase
          header_count_next = header_count + 2'd1;
        end else begin
          emit              = 1'b1;
          header_count_next = 2'd0;
          if (hdr_len[31] || hdr_len < 32'(ldsplit_pkg::MIN_DOC_LEN)) begin
            res.status       = ldsplit_pkg::ST_LEN_SHORT;
            phase_next       = PH_HALT;
            header_held_next = '0;
          end else begin
            // Send the first header byte now, queue the other three
            res.out_byte        = header_held[7:0];
            res.byte_valid      = 1'b1;
            res.run_last        = 1'b0;
            header_held_next    = {in_byte, header_held[23:8]};
            hdr_pend_next       = 2'd3;
            split_bytes_next    = split_bytes + 33'(ldsplit_pkg::HDR_BYTES);
            body_remaining_next = hdr_len[30:0] - 31'(ldsplit_pkg::HDR_BYTES);
            phase_next          = PH_BODY;
          end
        end
      end else begin
        // Body byte; on the last one close out the document
        emit                = 1'b1;
        res.out_byte        = in_byte;
        res.byte_valid      = 1'b1;
        split_bytes_next    = bytes_inc;
        body_remaining_next = rem_dec;
        if (rem_dec == 31'd0) begin
          res.doc_last      = 1'b1;
          res.split_close   = close_now;
          res.docs_in_split = docs_inc;
          phase_next        = PH_HEADER;
          if (close_now) begin
            split_index_next = split_index + 32'd1;
            split_bytes_next = '0;
            doc_count_next   = '0;
          end else begin
            doc_count_next = docs_inc;
          end
        end
      end
    end
  end

  // Control state, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      split_size_mb  <= ldsplit_pkg::SPLIT_MB_RESET;
      phase          <= PH_HEADER;
      header_held    <= '0;
      header_count   <= '0;
      hdr_pend       <= '0;
      body_remaining <= '0;
      split_bytes    <= '0;
      split_index    <= 32'd1;
      doc_count      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        split_size_mb <= cfg_wr_data;
      end
      phase          <= phase_next;
      header_held    <= header_held_next;
      header_count   <= header_count_next;
      hdr_pend       <= hdr_pend_next;
      body_remaining <= body_remaining_next;
      split_bytes    <= split_bytes_next;
      split_index    <= split_index_next;
      doc_count      <= doc_count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte      <= res.out_byte;
      byte_valid    <= res.byte_valid;
      split_number  <= res.split_number;
      doc_last      <= res.doc_last;
      split_close   <= res.split_close;
      docs_in_split <= res.docs_in_split;
      status        <= res.status;
      run_last      <= res.run_last;
    end
  end

  // Input stays closed while header bytes drain, and the output holds one
  a_pend_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (hdr_pend != 2'd0) |-> (!in_ready && out_valid && !run_last))
    else $error("input open or run ended while header bytes pending");

  // A status result never carries a byte and always ends its run
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ldsplit_pkg::ST_OK) |-> (run_last && !byte_valid && !doc_last))
    else $error("status result with byte or without run end");

  // Halt is final until reset
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALT) |=> (phase == PH_HALT))
    else $error("left halt without reset");

  // Header drain starts only from a valid fourth header byte
  a_pend_start: assert property (@(posedge clk) disable iff (rst)
    ($past(hdr_pend) == 2'd0 && hdr_pend != 2'd0) |-> (phase == PH_BODY && hdr_pend == 2'd3))
    else $error("header drain started outside a valid header");

endmodule
